>>> hdl/fbams_pkg.sv
// fbams_pkg: shared types and constants for the fixed block allocator.
// Commands, status codes, ALU operations and sequencer states.
// No dependencies.
package fbams_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 1024;
    localparam int unsigned CHUNK_RESET    = 128;
    localparam int unsigned CMD_W          = 2;
    localparam int unsigned IDX_PORT_W     = 10;
    localparam int unsigned CNT_PORT_W     = 11;
    localparam int unsigned STATUS_W       = 2;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_GC_BEGIN = 2'd1,
        CMD_MARK     = 2'd2,
        CMD_GC_END   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_GC_NEEDED = 2'd1,
        STAT_OOM       = 2'd2,
        STAT_MARK_OUT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_ADD = 2'd1,
        ALU_SUB = 2'd2
    } alu_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BASE,
        S_HAND,
        S_DECIDE,
        S_POP,
        S_OPEN,
        S_MARK,
        S_SWEEP
    } state_t;

endpackage

>>> hdl/fbams_alu.sv
// fbams_alu: shared multiply / add / subtract unit with registered result.
// Used by the allocator sequencer for all chunk arithmetic.
// Depends on fbams_pkg.
module fbams_alu #(
    parameter int unsigned CW = 11
) (
    input  logic                 clk,
    input  fbams_pkg::alu_op_t   op,
    input  logic [2*CW-1:0]      a,
    input  logic [CW-1:0]        b,
    output logic [2*CW-1:0]      res
);

    localparam int unsigned AW = 2 * CW;

    logic [AW-1:0] res_reg;
    logic [AW-1:0] res_next;

    always_comb
    begin
        unique case (op)
            fbams_pkg::ALU_MUL: res_next = AW'(a[CW-1:0]) * AW'(b);
            fbams_pkg::ALU_ADD: res_next = a + AW'(b);
            fbams_pkg::ALU_SUB: res_next = a - AW'(b);
            default:            res_next = a;
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

>>> hdl/fbams_ram.sv
// fbams_ram: single-port RAM, one access per cycle, registered read data.
// Holds the mark bitmap and the free stack of the allocator.
// Depends on fbams_pkg for default sizes.
module fbams_ram #(
    parameter int unsigned DEPTH = fbams_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned W     = 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  addr,
    input  logic [W-1:0]              wdata,
    output logic [W-1:0]              rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fixed_block_allocator_mark_sweep.sv
// fixed_block_allocator_mark_sweep: mark-and-sweep fixed block allocator.
// Sequencer over fbams_alu, a mark bitmap RAM and a free stack RAM (fbams_ram).
// Depends on fbams_pkg, fbams_alu, fbams_ram.
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+----------------------
//  command  | cmd, block_index                                | start && !busy
//  result   | status, granted_index, newly_marked,            | done, one cycle
//           | free_count, total_count                         |
//  config   | cfg_wdata (blocks_per_chunk)                    | cfg_we
//
// Every accepted word passes S_BASE, S_HAND and S_DECIDE, where bump grant, gc_needed
// and out-of-range mark finish; stack pop, chunk open, out_of_memory and mark go on
// to S_POP, S_OPEN or S_MARK, gc_begin clears the mark RAM in S_CLEAR and gc_end
// sweeps handed-out blocks in S_SWEEP; the shared ALU and one-port RAMs set this.
// After reset, busy stays high while the mark RAM clears.
// Results are never held off; each word is shown for one cycle with done.
module fixed_block_allocator_mark_sweep #(
    parameter int unsigned MAX_BLOCKS = fbams_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fbams_pkg::CMD_W-1:0]         cmd,
    input  logic [fbams_pkg::IDX_PORT_W-1:0]    block_index,
    output logic                                done,
    output logic [fbams_pkg::STATUS_W-1:0]      status,
    output logic [fbams_pkg::IDX_PORT_W-1:0]    granted_index,
    output logic                                newly_marked,
    output logic [fbams_pkg::CNT_PORT_W-1:0]    free_count,
    output logic [fbams_pkg::CNT_PORT_W-1:0]    total_count,
    input  logic                                cfg_we,
    input  logic [fbams_pkg::CNT_PORT_W-1:0]    cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CW    = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned AW    = 2 * CW;

    fbams_pkg::state_t  state_reg, state_next;
    fbams_pkg::cmd_t    cmd_reg, cmd_next;
    fbams_pkg::status_t status_reg, res_status;

    logic [fbams_pkg::IDX_PORT_W-1:0] idx_reg, idx_next;
    logic [fbams_pkg::CNT_PORT_W-1:0] chunk_cfg_reg;

    logic [CW-1:0]    fd_reg, fd_next;
    logic [CW-1:0]    open_reg, open_next;
    logic [CW-1:0]    bump_reg, bump_next;
    logic             jc_reg, jc_next;
    logic [AW-1:0]    prod_reg, prod_next;
    logic [CW-1:0]    tot_reg, tot_next;
    logic [CW-1:0]    limit_reg, limit_next;
    logic [CW-1:0]    sw_reg, sw_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_addr_reg, pend_addr_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             report_reg, report_next;

    logic             done_reg;
    logic [IDX_W-1:0] granted_reg, res_granted;
    logic             fresh_reg, res_fresh;
    logic [CW-1:0]    free_reg;
    logic [CW-1:0]    total_reg;
    logic             finish;

    logic [CW-1:0]    chunk;
    logic [CW-1:0]    hand_sat;
    logic [CW-1:0]    mark_limit;
    logic             bump_ok;

    fbams_pkg::alu_op_t alu_op;
    logic [AW-1:0]      alu_a;
    logic [CW-1:0]      alu_b;
    logic [AW-1:0]      alu_res;

    logic             mark_we, mark_re, mark_wdata, mark_rdata;
    logic [IDX_W-1:0] mark_addr;
    logic             stk_we, stk_re;
    logic [IDX_W-1:0] stk_addr, stk_wdata, stk_rdata;

    fbams_alu #(
        .CW (CW)
    ) u_alu (
        .clk (clk),
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    fbams_ram #(
        .DEPTH (MAX_BLOCKS),
        .W     (1)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .re    (mark_re),
        .addr  (mark_addr),
        .wdata (mark_wdata),
        .rdata (mark_rdata)
    );

    fbams_ram #(
        .DEPTH (MAX_BLOCKS),
        .W     (IDX_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .re    (stk_re),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    // clamp chunk size to 1..MAX_BLOCKS
    always_comb
    begin
        if (chunk_cfg_reg == '0)
        begin
            chunk = CW'(1);
        end
        else if (32'(chunk_cfg_reg) > 32'(MAX_BLOCKS))
        begin
            chunk = CW'(MAX_BLOCKS);
        end
        else
        begin
            chunk = CW'(chunk_cfg_reg);
        end
    end

    assign hand_sat   = (alu_res > AW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(alu_res);
    assign mark_limit = (prod_reg > AW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(prod_reg);
    assign bump_ok    = (bump_reg < chunk) && (alu_res < AW'(MAX_BLOCKS));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        fd_next        = fd_reg;
        open_next      = open_reg;
        bump_next      = bump_reg;
        jc_next        = jc_reg;
        prod_next      = prod_reg;
        tot_next       = tot_reg;
        limit_next     = limit_reg;
        sw_next        = sw_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        clr_next       = clr_reg;
        report_next    = report_reg;
        alu_op         = fbams_pkg::ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;
        mark_we        = 1'b0;
        mark_re        = 1'b0;
        mark_addr      = '0;
        mark_wdata     = 1'b0;
        stk_we         = 1'b0;
        stk_re         = 1'b0;
        stk_addr       = '0;
        stk_wdata      = '0;
        finish         = 1'b0;
        res_status     = fbams_pkg::STAT_OK;
        res_granted    = '0;
        res_fresh      = 1'b0;

        unique case (state_reg)
            fbams_pkg::S_CLEAR:
            begin
                mark_we   = 1'b1;
                mark_addr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(MAX_BLOCKS - 1))
                begin
                    clr_next    = '0;
                    finish      = report_reg;
                    report_next = 1'b0;
                    state_next  = fbams_pkg::S_IDLE;
                end
            end

            fbams_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = fbams_pkg::cmd_t'(cmd);
                    idx_next   = block_index;
                    alu_op     = fbams_pkg::ALU_MUL;
                    alu_a      = AW'(open_reg);
                    alu_b      = chunk;
                    state_next = fbams_pkg::S_BASE;
                end
            end

            fbams_pkg::S_BASE:
            begin
                // alu_res = open_chunks * chunk
                prod_next  = alu_res;
                alu_op     = fbams_pkg::ALU_SUB;
                alu_a      = alu_res;
                alu_b      = chunk;
                state_next = fbams_pkg::S_HAND;
            end

            fbams_pkg::S_HAND:
            begin
                // alu_res = base of current chunk
                alu_op     = fbams_pkg::ALU_ADD;
                alu_a      = alu_res;
                alu_b      = bump_reg;
                state_next = fbams_pkg::S_DECIDE;
            end

            fbams_pkg::S_DECIDE:
            begin
                // alu_res = base + bump
                tot_next = hand_sat;
                unique case (cmd_reg)
                    fbams_pkg::CMD_ALLOC:
                    begin
                        if (fd_reg != '0)
                        begin
                            fd_next    = fd_reg - 1'b1;
                            stk_re     = 1'b1;
                            stk_addr   = IDX_W'(fd_reg - 1'b1);
                            jc_next    = 1'b0;
                            state_next = fbams_pkg::S_POP;
                        end
                        else if (bump_ok)
                        begin
                            res_granted = IDX_W'(alu_res);
                            bump_next   = bump_reg + 1'b1;
                            jc_next     = 1'b0;
                            tot_next    = CW'(alu_res) + 1'b1;
                            finish      = 1'b1;
                            state_next  = fbams_pkg::S_IDLE;
                        end
                        else if (!jc_reg)
                        begin
                            res_status = fbams_pkg::STAT_GC_NEEDED;
                            finish     = 1'b1;
                            state_next = fbams_pkg::S_IDLE;
                        end
                        else
                        begin
                            alu_op     = fbams_pkg::ALU_ADD;
                            alu_a      = prod_reg;
                            alu_b      = chunk;
                            state_next = fbams_pkg::S_OPEN;
                        end
                    end

                    fbams_pkg::CMD_GC_BEGIN:
                    begin
                        jc_next     = 1'b0;
                        report_next = 1'b1;
                        clr_next    = '0;
                        state_next  = fbams_pkg::S_CLEAR;
                    end

                    fbams_pkg::CMD_MARK:
                    begin
                        if (32'(idx_reg) >= 32'(mark_limit))
                        begin
                            res_status = fbams_pkg::STAT_MARK_OUT;
                            finish     = 1'b1;
                            state_next = fbams_pkg::S_IDLE;
                        end
                        else
                        begin
                            mark_re    = 1'b1;
                            mark_addr  = IDX_W'(idx_reg);
                            state_next = fbams_pkg::S_MARK;
                        end
                    end

                    fbams_pkg::CMD_GC_END:
                    begin
                        fd_next    = '0;
                        sw_next    = '0;
                        limit_next = hand_sat;
                        jc_next    = 1'b1;
                        state_next = fbams_pkg::S_SWEEP;
                    end

                    default:
                    begin
                        state_next = fbams_pkg::S_IDLE;
                    end
                endcase
            end

            fbams_pkg::S_POP:
            begin
                res_granted = stk_rdata;
                finish      = 1'b1;
                state_next  = fbams_pkg::S_IDLE;
            end

            fbams_pkg::S_OPEN:
            begin
                // alu_res = (open_chunks + 1) * chunk
                if (alu_res <= AW'(MAX_BLOCKS))
                begin
                    res_granted = IDX_W'(prod_reg);
                    open_next   = open_reg + 1'b1;
                    bump_next   = CW'(1);
                    jc_next     = 1'b0;
                    tot_next    = CW'(prod_reg) + 1'b1;
                end
                else
                begin
                    res_status = fbams_pkg::STAT_OOM;
                end
                finish     = 1'b1;
                state_next = fbams_pkg::S_IDLE;
            end

            fbams_pkg::S_MARK:
            begin
                if (!mark_rdata)
                begin
                    mark_we    = 1'b1;
                    mark_addr  = IDX_W'(idx_reg);
                    mark_wdata = 1'b1;
                    res_fresh  = 1'b1;
                end
                finish     = 1'b1;
                state_next = fbams_pkg::S_IDLE;
            end

            fbams_pkg::S_SWEEP:
            begin
                // read bit sw, push the previous address if unmarked
                if (pend_reg && !mark_rdata)
                begin
                    stk_we    = 1'b1;
                    stk_addr  = IDX_W'(fd_reg);
                    stk_wdata = pend_addr_reg;
                    fd_next   = fd_reg + 1'b1;
                end
                if (sw_reg < limit_reg)
                begin
                    mark_re        = 1'b1;
                    mark_addr      = IDX_W'(sw_reg);
                    pend_next      = 1'b1;
                    pend_addr_next = IDX_W'(sw_reg);
                    sw_next        = sw_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    finish     = 1'b1;
                    state_next = fbams_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fbams_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbams_pkg::S_CLEAR;
            chunk_cfg_reg <= fbams_pkg::CNT_PORT_W'(fbams_pkg::CHUNK_RESET);
            fd_reg        <= '0;
            open_reg      <= CW'(1);
            bump_reg      <= '0;
            jc_reg        <= 1'b0;
            sw_reg        <= '0;
            pend_reg      <= 1'b0;
            clr_reg       <= '0;
            report_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fd_reg     <= fd_next;
            open_reg   <= open_next;
            bump_reg   <= bump_next;
            jc_reg     <= jc_next;
            sw_reg     <= sw_next;
            pend_reg   <= pend_next;
            clr_reg    <= clr_next;
            report_reg <= report_next;
            done_reg   <= finish;
            if (cfg_we)
            begin
                chunk_cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        prod_reg      <= prod_next;
        tot_reg       <= tot_next;
        limit_reg     <= limit_next;
        pend_addr_reg <= pend_addr_next;
        if (finish)
        begin
            status_reg  <= res_status;
            granted_reg <= res_granted;
            fresh_reg   <= res_fresh;
            free_reg    <= fd_next;
            total_reg   <= tot_next;
        end
    end

    assign busy          = (state_reg != fbams_pkg::S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_index = fbams_pkg::IDX_PORT_W'(granted_reg);
    assign newly_marked  = fresh_reg;
    assign free_count    = fbams_pkg::CNT_PORT_W'(free_reg);
    assign total_count   = fbams_pkg::CNT_PORT_W'(total_reg);

endmodule

>>> hdl/fbams_checker.sv
// fbams_checker: port-level assertions for the fixed block allocator.
// Bound to fixed_block_allocator_mark_sweep; depends on fbams_pkg.
module fbams_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [fbams_pkg::STATUS_W-1:0]    status,
    input logic [fbams_pkg::IDX_PORT_W-1:0]  granted_index,
    input logic                              newly_marked
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted word");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word repeated");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != fbams_pkg::STAT_OK) |-> (granted_index == '0) && !newly_marked)
        else $error("failed command carries grant or mark");

    a_mark_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && newly_marked |-> (status == fbams_pkg::STAT_OK))
        else $error("new mark with error status");

endmodule

bind fixed_block_allocator_mark_sweep fbams_checker u_fbams_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .granted_index (granted_index),
    .newly_marked  (newly_marked)
);

>>> tb/fixed_block_allocator_mark_sweep_test.sv
// Self-checking bench for fixed_block_allocator_mark_sweep: directed and random
// command words against an in-bench allocator predictor, config phases in between.
// Depends on fbams_pkg and the allocator RTL.
module fixed_block_allocator_mark_sweep_test;

    localparam int unsigned POOL        = fbams_pkg::MAX_BLOCKS_DEF;
    localparam int          PLANNER     = 0;
    localparam int          CHECKER     = 1;
    localparam int unsigned RANDOM_WORDS = 2000;
    localparam int unsigned STALL_LIMIT = 8000;
    localparam int unsigned CALM_TAIL   = 300;

    typedef struct packed {
        bit              is_cfg;
        logic [10:0]     cfg_val;
        fbams_pkg::cmd_t op;
        logic [9:0]      idx;
    } word_t;

    typedef struct packed {
        fbams_pkg::status_t status;
        logic [9:0]         granted;
        logic               fresh;
        logic [10:0]        free_num;
        logic [10:0]        total_cnt;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = fbams_pkg::CMD_ALLOC;
    logic [9:0]  block_index = '0;
    logic        done;
    logic [1:0]  status;
    logic [9:0]  granted_index;
    logic        newly_marked;
    logic [10:0] free_count;
    logic [10:0] total_count;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;

    fixed_block_allocator_mark_sweep uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .block_index  (block_index),
        .done         (done),
        .status       (status),
        .granted_index(granted_index),
        .newly_marked (newly_marked),
        .free_count   (free_count),
        .total_count  (total_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Two copies of the allocator state: one steers stimulus, one checks the DUT.
    bit          mark_map    [2][POOL];
    logic [9:0]  free_stk    [2][POOL];
    int unsigned free_top    [2];
    int unsigned chunks_open [2];
    int unsigned bump_pos    [2];
    int unsigned chunk_cfg   [2];
    bit          after_sweep [2];

    word_t       pending_words[$];
    reply_t      awaited_replies[$];
    int unsigned random_words = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    int unsigned gap_left = 0;
    logic        took = 1'b0;
    int unsigned cfg_choices [8] = '{1, 0, 3, 1024, 6, 2047, 2, 128};

    function automatic void pool_reset(int w);
        for (int i = 0; i < POOL; i++)
        begin
            mark_map[w][i] = 1'b0;
            free_stk[w][i] = '0;
        end
        free_top[w] = 0;
        chunks_open[w] = 1;
        bump_pos[w] = 0;
        chunk_cfg[w] = fbams_pkg::CHUNK_RESET;
        after_sweep[w] = 1'b0;
    endfunction

    function automatic int unsigned eff_chunk(int w);
        int unsigned c;
        c = chunk_cfg[w];
        if (c == 0)
            c = 1;
        if (c > POOL)
            c = POOL;
        return c;
    endfunction

    function automatic int unsigned handed_out_count(int w);
        int unsigned t;
        t = (chunks_open[w] - 1) * eff_chunk(w) + bump_pos[w];
        return (t > POOL) ? POOL : t;
    endfunction

    function automatic reply_t allocator_predict(int w, fbams_pkg::cmd_t op, logic [9:0] idx);
        reply_t      r;
        int unsigned c, base, lim;
        r = '0;
        c = eff_chunk(w);
        base = (chunks_open[w] - 1) * c;
        case (op)
            fbams_pkg::CMD_ALLOC:
            begin
                if (free_top[w] > 0)
                begin
                    free_top[w]--;
                    r.granted = free_stk[w][free_top[w]];
                    after_sweep[w] = 1'b0;
                end
                else if (bump_pos[w] < c && base + bump_pos[w] < POOL)
                begin
                    r.granted = 10'(base + bump_pos[w]);
                    bump_pos[w]++;
                    after_sweep[w] = 1'b0;
                end
                else if (!after_sweep[w])
                    r.status = fbams_pkg::STAT_GC_NEEDED;
                else if (chunks_open[w] * c + c <= POOL)
                begin
                    r.granted = 10'(chunks_open[w] * c);
                    chunks_open[w]++;
                    bump_pos[w] = 1;
                    after_sweep[w] = 1'b0;
                end
                else
                    r.status = fbams_pkg::STAT_OOM;
            end
            fbams_pkg::CMD_GC_BEGIN:
            begin
                for (int i = 0; i < POOL; i++)
                    mark_map[w][i] = 1'b0;
                after_sweep[w] = 1'b0;
            end
            fbams_pkg::CMD_MARK:
            begin
                lim = chunks_open[w] * c;
                if (lim > POOL)
                    lim = POOL;
                if (idx >= lim)
                    r.status = fbams_pkg::STAT_MARK_OUT;
                else if (!mark_map[w][idx])
                begin
                    mark_map[w][idx] = 1'b1;
                    r.fresh = 1'b1;
                end
            end
            default:
            begin
                lim = handed_out_count(w);
                free_top[w] = 0;
                for (int i = 0; i < lim; i++)
                begin
                    if (!mark_map[w][i])
                    begin
                        free_stk[w][free_top[w]] = 10'(i);
                        free_top[w]++;
                    end
                end
                after_sweep[w] = 1'b1;
            end
        endcase
        r.free_num = 11'(free_top[w]);
        r.total_cnt = 11'(handed_out_count(w));
        return r;
    endfunction

    task automatic add_word(fbams_pkg::cmd_t op, int unsigned idx);
        word_t wd;
        wd = '0;
        wd.op = op;
        wd.idx = 10'(idx);
        pending_words.push_back(wd);
        void'(allocator_predict(PLANNER, op, wd.idx));
        random_words++;
    endtask

    task automatic add_cfg(int unsigned val);
        word_t wd;
        wd = '0;
        wd.is_cfg = 1'b1;
        wd.cfg_val = 11'(val);
        pending_words.push_back(wd);
        chunk_cfg[PLANNER] = val;
    endtask

    // gc_begin, marks, gc_end; a full marking lets the next allocate open a chunk
    task automatic add_collection();
        int unsigned t, k;
        t = handed_out_count(PLANNER);
        if ($urandom_range(0, 9) != 0)
            add_word(fbams_pkg::CMD_GC_BEGIN, $urandom_range(0, 1023));
        if (t > 0 && t <= 48 && $urandom_range(0, 1) == 1)
        begin
            k = $urandom_range(0, t - 1);
            for (int n = 0; n < t; n++)
                add_word(fbams_pkg::CMD_MARK, (n + k) % t);
        end
        else if (t > 0)
        begin
            repeat ($urandom_range(0, 16))
                add_word(fbams_pkg::CMD_MARK, $urandom_range(0, t - 1));
        end
        if ($urandom_range(0, 7) == 0)
            add_word(fbams_pkg::CMD_MARK, $urandom_range(0, 1023));
        if ($urandom_range(0, 9) != 0)
            add_word(fbams_pkg::CMD_GC_END, $urandom_range(0, 1023));
    endtask

    always @(negedge clk)
    begin
        logic  go, we;
        word_t head;
        go = 1'b0;
        we = 1'b0;
        if (rst_n)
        begin
            if (start && !took)
                go = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (pending_words.size() > 0)
            begin
                head = pending_words[0];
                if (head.is_cfg)
                begin
                    if (awaited_replies.size() == 0 && !busy)
                    begin
                        we = 1'b1;
                        cfg_wdata <= head.cfg_val;
                        void'(pending_words.pop_front());
                    end
                end
                else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(0, 5);
                else
                begin
                    go = 1'b1;
                    cmd <= head.op;
                    block_index <= head.idx;
                    void'(pending_words.pop_front());
                end
            end
        end
        start <= go;
        cfg_we <= we;
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            took <= start && !busy;
            if (start && !busy)
                awaited_replies.push_back(
                    allocator_predict(CHECKER, fbams_pkg::cmd_t'(cmd), block_index));
            if (cfg_we)
                chunk_cfg[CHECKER] = cfg_wdata;
            if ((start && !busy) || done || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (done)
            begin
                if (awaited_replies.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word: status %0d granted %0d",
                                 status, granted_index);
                    mismatches++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (want.status !== status || want.granted !== granted_index ||
                        want.fresh !== newly_marked || want.free_num !== free_count ||
                        want.total_cnt !== total_count)
                    begin
                        if (mismatches < 10)
                            $display({"result word mismatch: expected st %0d idx %0d new %0d ",
                                      "free %0d total %0d, got st %0d idx %0d new %0d ",
                                      "free %0d total %0d"},
                                     want.status, want.granted, want.fresh, want.free_num,
                                     want.total_cnt, status, granted_index, newly_marked,
                                     free_count, total_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned pick, phase;
        pool_reset(PLANNER);
        pool_reset(CHECKER);

        // directed: bump, gc_needed, marks, sweep, pop, chunk open, early sweep, OOM
        add_cfg(4);
        repeat (4)
            add_word(fbams_pkg::CMD_ALLOC, 0);
        add_word(fbams_pkg::CMD_ALLOC, 1023);
        add_word(fbams_pkg::CMD_GC_BEGIN, 0);
        add_word(fbams_pkg::CMD_MARK, 0);
        add_word(fbams_pkg::CMD_MARK, 0);
        add_word(fbams_pkg::CMD_MARK, 1023);
        add_word(fbams_pkg::CMD_MARK, 1);
        add_word(fbams_pkg::CMD_MARK, 2);
        add_word(fbams_pkg::CMD_MARK, 3);
        add_word(fbams_pkg::CMD_GC_END, 0);
        add_word(fbams_pkg::CMD_ALLOC, 0);
        add_word(fbams_pkg::CMD_MARK, 7);
        add_word(fbams_pkg::CMD_GC_END, 0);
        add_word(fbams_pkg::CMD_ALLOC, 0);
        add_word(fbams_pkg::CMD_MARK, 4);
        add_word(fbams_pkg::CMD_GC_END, 0);
        add_cfg(2047);
        add_word(fbams_pkg::CMD_ALLOC, 0);
        add_word(fbams_pkg::CMD_ALLOC, 0);
        add_word(fbams_pkg::CMD_MARK, 1023);

        random_words = 0;
        phase = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if (random_words >= phase * 250 && phase < 8)
            begin
                add_cfg(cfg_choices[phase]);
                phase++;
            end
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                repeat ($urandom_range(1, 12))
                    add_word(fbams_pkg::CMD_ALLOC, $urandom_range(0, 1023));
            end
            else if (pick < 8)
                add_collection();
            else
                add_word(fbams_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 1023));
        end

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || awaited_replies.size() > 0 || start)
            @(posedge clk);
        repeat (1100)
            @(posedge clk);
        if (mismatches == 0 && awaited_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
hdl/fbams_pkg.sv
hdl/fbams_alu.sv
hdl/fbams_ram.sv
hdl/fixed_block_allocator_mark_sweep.sv
hdl/fbams_checker.sv
tb/fixed_block_allocator_mark_sweep_test.sv
